>>> hw/rtl/triangle_tangent_frame_macros.svh
// ----------------------------------------------------------------------------
// Triangle tangent frame assertion macros
// Shared assertion helpers for the tangent frame checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_FRAME_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TTF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define TTF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ttf_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame package
// Widths, register indexes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned CfgWidth = 17;
  localparam int unsigned NormWidth = 18;

  localparam logic [0:0] CfgDetThr = 1'b0;
  localparam logic [0:0] CfgLenThr = 1'b1;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DET,
    ST_NUM,
    ST_DIVU,
    ST_DIVW,
    ST_SQ,
    ST_SQRT,
    ST_SQRTW,
    ST_NRM,
    ST_NRMW,
    ST_CROSS,
    ST_DOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

>>> hw/rtl/ttf_iter_unit.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame iterative unit
// Shared restoring divider and integer square root, one bit per cycle.
// ----------------------------------------------------------------------------
module ttf_iter_unit
  import ttf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  unit_req_t          req,
  input  logic signed [63:0] num,
  input  logic signed [32:0] den,
  input  logic        [63:0] rad,
  output logic               done,
  output logic signed [63:0] quo
);

  logic        [6:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  op_t                op_r, op_nxt;
  logic               neg_r, neg_nxt;
  logic        [63:0] q_r, q_nxt;
  logic        [64:0] rem_r, rem_nxt;
  logic        [63:0] a_r, a_nxt;
  logic        [31:0] d_r, d_nxt;
  logic        [64:0] trial;
  logic        [65:0] strial;
  logic        [65:0] srem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    a_r   <= a_nxt;
    d_r   <= d_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    a_nxt    = a_r;
    d_nxt    = d_r;
    done_nxt = 1'b0;
    trial    = {rem_r[63:0], a_r[63]} - {33'd0, d_r};
    srem     = {rem_r[63:0], a_r[63:62]};
    strial   = srem - {q_r, 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = req.op;
      q_nxt    = '0;
      rem_nxt  = '0;
      if (req.op == OP_DIV) begin
        neg_nxt = num[63] ^ den[32];
        a_nxt   = num[63] ? 64'(-num) : 64'(num);
        d_nxt   = den[32] ? 32'(-den) : 32'(den);
      end else begin
        neg_nxt = 1'b0;
        a_nxt   = rad;
      end
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        a_nxt = {a_r[62:0], 1'b0};
        if (!trial[64]) begin
          rem_nxt = trial;
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[63:0], a_r[63]};
          q_nxt   = {q_r[62:0], 1'b0};
        end
        if (cnt_r == 7'd63) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        a_nxt = {a_r[61:0], 2'b00};
        if (!strial[65]) begin
          rem_nxt = strial[64:0];
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = srem[64:0];
          q_nxt   = {q_r[62:0], 1'b0};
        end
        if (cnt_r == 7'd31) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
      cnt_nxt = cnt_r + 7'd1;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

>>> hw/rtl/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame
// Per-triangle unit tangent and handedness from three corner requests.
// ----------------------------------------------------------------------------
// Corners 0 and 1 are stored at their accepting edge and busy never rises for them.
// Corner 2 keeps busy high through six divides, one square root, three normalising
// divides and the sequencing steps; a degenerate determinant ends the sequence before
// the divides and a short tangent ends it before the normalising divides. out_valid
// is high for one cycle when the sequence ends. Synchronous active-low reset clears
// the sequencer and sets thresholds to 1.
module triangle_tangent_frame
  import ttf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [31:0]   in_tex_u,
  input  logic signed [31:0]   in_tex_v,
  input  logic signed [17:0]   in_normal_x,
  input  logic signed [17:0]   in_normal_y,
  input  logic signed [17:0]   in_normal_z,
  input  logic        [1:0]    in_corner,
  output logic                 out_valid,
  output logic signed [17:0]   out_tangent_x,
  output logic signed [17:0]   out_tangent_y,
  output logic signed [17:0]   out_tangent_z,
  output logic                 out_handed_negative,
  output logic                 out_fallback_used,
  input  logic                 cfg_we,
  input  logic        [0:0]    cfg_index,
  input  logic        [16:0]   cfg_data
);

  state_t state_r, state_nxt;
  logic [CfgWidth-1:0] det_thr_r, len_thr_r;
  logic signed [31:0] pos_r [6];
  logic signed [31:0] tex_r [4];
  logic signed [NormWidth-1:0] nrm_r [3];
  logic signed [31:0] e1_r [3], e2_r [3];
  logic signed [31:0] du1_r, dv1_r, du2_r, dv2_r, det_r;
  logic signed [31:0] u_r [3], b_r [3];
  logic signed [31:0] num_r, num_nxt;
  logic        [2:0]  idx_r, idx_nxt;
  logic        [1:0]  cidx;
  logic        [63:0] sq_r;
  logic        [31:0] len_r;
  logic signed [63:0] tn_r [3];
  logic signed [31:0] cr_r [3];
  logic signed [31:0] opa0, opb0, opa1, opb1;
  logic signed [63:0] prod_a, prod_b;
  logic signed [63:0] m0, m1;
  logic               neg_r, fb_r, valid_r;
  logic signed [17:0] tx_r, ty_r, tz_r;
  unit_req_t          req;
  logic               udone;
  logic signed [63:0] uquo;
  logic signed [63:0] unum;
  logic signed [32:0] uden;
  logic               accept;
  logic signed [32:0] e1d [3], e2d [3];
  logic signed [31:0] det_w;
  logic        [31:0] det_mag;
  logic               det_fb, len_fb;
  logic signed [63:0] dsum;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign cidx   = idx_r[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r <= CfgWidth'(1);
      len_thr_r <= CfgWidth'(1);
    end else if (cfg_we) begin
      if (cfg_index == CfgDetThr) det_thr_r <= cfg_data;
      else if (cfg_index == CfgLenThr) len_thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_corner == 2'd0) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      tex_r[0] <= in_tex_u;
      tex_r[1] <= in_tex_v;
      nrm_r[0] <= in_normal_x;
      nrm_r[1] <= in_normal_y;
      nrm_r[2] <= in_normal_z;
    end
    if (accept && in_corner == 2'd1) begin
      pos_r[3] <= in_pos_x;
      pos_r[4] <= in_pos_y;
      pos_r[5] <= in_pos_z;
      tex_r[2] <= in_tex_u;
      tex_r[3] <= in_tex_v;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1d[i] = 33'(pos_r[3+i]) - 33'(pos_r[i]);
      e2d[i] = 33'(i == 0 ? in_pos_x : (i == 1 ? in_pos_y : in_pos_z)) - 33'(pos_r[i]);
    end
  end

  // Shared multiplier pair: operands picked by the sequencer step.
  always_comb begin
    opa0 = '0;
    opb0 = '0;
    opa1 = '0;
    opb1 = '0;
    case (state_r)
      ST_DET: begin
        opa0 = du1_r;
        opb0 = dv2_r;
        opa1 = du2_r;
        opb1 = dv1_r;
      end
      ST_NUM: begin
        if (!idx_r[2]) begin
          opa0 = dv2_r;
          opb0 = e1_r[cidx];
          opa1 = dv1_r;
          opb1 = e2_r[cidx];
        end else begin
          opa0 = du1_r;
          opb0 = e2_r[cidx];
          opa1 = du2_r;
          opb1 = e1_r[cidx];
        end
      end
      ST_SQ: begin
        opa0 = u_r[cidx];
        opb0 = u_r[cidx];
      end
      ST_CROSS: begin
        case (cidx)
          2'd0: begin
            opa0 = 32'(nrm_r[1]);
            opb0 = tn_r[2][31:0];
            opa1 = 32'(nrm_r[2]);
            opb1 = tn_r[1][31:0];
          end
          2'd1: begin
            opa0 = 32'(nrm_r[2]);
            opb0 = tn_r[0][31:0];
            opa1 = 32'(nrm_r[0]);
            opb1 = tn_r[2][31:0];
          end
          default: begin
            opa0 = 32'(nrm_r[0]);
            opb0 = tn_r[1][31:0];
            opa1 = 32'(nrm_r[1]);
            opb1 = tn_r[0][31:0];
          end
        endcase
      end
      ST_DOT: begin
        opa0 = cr_r[cidx];
        opb0 = b_r[cidx];
      end
      default: begin
        opa0 = '0;
      end
    endcase
    prod_a = opa0 * opb0;
    prod_b = opa1 * opb1;
    m0 = prod_a >>> FRAC_BITS;
    m1 = prod_b >>> FRAC_BITS;
  end

  assign det_w   = sat32(66'(m0) - 66'(m1));
  assign det_mag = det_w[31] ? 32'(-det_w) : 32'(det_w);
  assign det_fb  = (det_w == 32'sd0) || ({1'b0, det_mag} < 33'(det_thr_r));
  assign len_fb  = (len_r == 32'd0) || ({1'b0, len_r} < 33'(len_thr_r));

  assign unum = (state_r == ST_NRM) ? 64'(u_r[cidx]) <<< FRAC_BITS
                                    : 64'(num_r) <<< FRAC_BITS;
  assign uden = (state_r == ST_NRM) ? $signed({1'b0, len_r}) : 33'(det_r);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    num_nxt   = num_r;
    req       = '{start: 1'b0, op: OP_DIV};
    case (state_r)
      ST_IDLE: begin
        if (accept && in_corner == 2'd2) begin
          state_nxt = ST_DET;
        end
      end
      ST_DET: begin
        state_nxt = det_fb ? ST_OUT : ST_NUM;
        idx_nxt   = '0;
      end
      ST_NUM: begin
        num_nxt   = sat32(66'(m0) - 66'(m1));
        state_nxt = ST_DIVU;
      end
      ST_DIVU: begin
        req       = '{start: 1'b1, op: OP_DIV};
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (udone) begin
          if (idx_r == 3'd6) begin
            state_nxt = ST_SQ;
            idx_nxt   = '0;
          end else begin
            idx_nxt   = (cidx == 2'd2) ? 3'd4 : idx_r + 3'd1;
            state_nxt = ST_NUM;
          end
        end
      end
      ST_SQ: begin
        if (cidx == 2'd2) begin
          state_nxt = ST_SQRT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_SQRT: begin
        req       = '{start: 1'b1, op: OP_SQRT};
        state_nxt = ST_SQRTW;
      end
      ST_SQRTW: begin
        if (udone) begin
          idx_nxt   = '0;
          state_nxt = ST_NRM;
        end
      end
      ST_NRM: begin
        if (len_fb) begin
          state_nxt = ST_OUT;
        end else begin
          req       = '{start: 1'b1, op: OP_DIV};
          state_nxt = ST_NRMW;
        end
      end
      ST_NRMW: begin
        if (udone) begin
          if (cidx == 2'd2) begin
            idx_nxt   = '0;
            state_nxt = ST_CROSS;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = ST_NRM;
          end
        end
      end
      ST_CROSS: begin
        if (cidx == 2'd2) begin
          idx_nxt   = '0;
          state_nxt = ST_DOT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_DOT: begin
        if (cidx == 2'd2) begin
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == ST_OUT);
    end
    idx_r <= idx_nxt;
    num_r <= num_nxt;
    if (accept && in_corner == 2'd2) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= sat32(66'(e1d[i]));
        e2_r[i] <= sat32(66'(e2d[i]));
      end
      du1_r <= sat32(66'(tex_r[2]) - 66'(tex_r[0]));
      dv1_r <= sat32(66'(tex_r[3]) - 66'(tex_r[1]));
      du2_r <= sat32(66'(in_tex_u) - 66'(tex_r[0]));
      dv2_r <= sat32(66'(in_tex_v) - 66'(tex_r[1]));
      sq_r  <= '0;
      fb_r  <= 1'b0;
      neg_r <= 1'b0;
      dsum  <= '0;
    end
    case (state_r)
      ST_DET: begin
        det_r <= det_w;
        if (det_fb) fb_r <= 1'b1;
      end
      ST_DIVW: begin
        if (udone) begin
          if (!idx_r[2]) u_r[cidx] <= sat32(66'(uquo));
          else b_r[cidx] <= sat32(66'(uquo));
        end
      end
      ST_SQ: sq_r <= sq_r + $unsigned(prod_a);
      ST_SQRTW: if (udone) len_r <= uquo[31:0];
      ST_NRM: begin
        if (len_fb) fb_r <= 1'b1;
      end
      ST_NRMW: if (udone) tn_r[cidx] <= uquo;
      ST_CROSS: cr_r[cidx] <= 32'(m0 - m1);
      ST_DOT: begin
        if (cidx == 2'd2) neg_r <= (dsum + prod_a) < 64'sd0;
        dsum <= dsum + prod_a;
      end
      ST_OUT: begin
        if (fb_r) begin
          tx_r <= 18'sd1 <<< FRAC_BITS;
          ty_r <= '0;
          tz_r <= '0;
        end else begin
          tx_r <= tn_r[0][17:0];
          ty_r <= tn_r[1][17:0];
          tz_r <= tn_r[2][17:0];
        end
      end
      default: begin
      end
    endcase
  end

  ttf_iter_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .num  (unum),
    .den  (uden),
    .rad  (sq_r),
    .done (udone),
    .quo  (uquo)
  );

  assign out_valid           = valid_r;
  assign out_tangent_x       = tx_r;
  assign out_tangent_y       = ty_r;
  assign out_tangent_z       = tz_r;
  assign out_handed_negative = fb_r ? 1'b0 : neg_r;
  assign out_fallback_used   = fb_r;

endmodule

>>> hw/rtl/ttf_checker.sv
// ----------------------------------------------------------------------------
// Triangle tangent frame checker
// Port-level properties of the tangent frame, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_tangent_frame_macros.svh"

module ttf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic        [1:0] in_corner,
  input logic              out_valid,
  input logic              out_handed_negative,
  input logic              out_fallback_used
);

  `TTF_ASSERT_NEXT(a_store_no_busy, clk, rst_n, start && !busy && in_corner != 2'd2, !busy, "store request raised busy")
  `TTF_ASSERT_NEXT(a_trigger_busy, clk, rst_n, start && !busy && in_corner == 2'd2, busy, "corner two did not start work")
  `TTF_ASSERT_NEXT(a_single_pulse, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `TTF_ASSERT_IMP(a_fallback_pos, clk, rst_n, out_valid && out_fallback_used, !out_handed_negative, "fallback with negative handedness")

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_corner          (in_corner),
  .out_valid          (out_valid),
  .out_handed_negative(out_handed_negative),
  .out_fallback_used  (out_fallback_used)
);
